// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every rising clock edge outside reset
`define SWHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define SWHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/swhc_pkg.sv -----
// ----------------------------------------------------------------------------
// swhc_pkg
// Shared constants and types of the sliding window hit counter.
// ----------------------------------------------------------------------------
package swhc_pkg;

  localparam int WINDOW    = 300;
  localparam int COUNT_W   = 16;
  localparam int TS_W      = 31;
  localparam int TOTAL_W   = 25;
  localparam int IDX_W     = $clog2(WINDOW);
  localparam int ENTRY_W   = TS_W + COUNT_W;
  localparam int DIFF_W    = TS_W + 1;

  // rounded-up reciprocal of the window, exact for every timestamp
  localparam int RECIP_SHIFT = TS_W + IDX_W;
  localparam int PROD_W      = 2 * TS_W + 1;
  localparam logic [TS_W:0] RECIP =
    (TS_W + 1)'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic FUNC_HIT   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MOD    = 8'b0000_0100,
    S_HRD    = 8'b0000_1000,
    S_HWR    = 8'b0001_0000,
    S_QRUN   = 8'b0010_0000,
    S_QDRAIN = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

endpackage

// ----- hw/rtl/swhc_ram.sv -----
// ----------------------------------------------------------------------------
// swhc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/sliding_window_hit_counter_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_hit_counter_top
// Hit counter over a sliding window kept as a ring of time/count slots.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 300-entry slot memory to zero, one slot a
// cycle, and takes no beat while it sweeps. A hit beat (tuser low) steps
// through the accept, a multiply of the timestamp by a rounded-up
// reciprocal of the window to find its slot, then one read and one write of
// the slot. In a query beat (tuser high) the single read port of the slot
// memory is walked over all 300 slots, one a cycle, and the counts of slots
// inside the window are summed; the total then goes to the output register
// once that is free. A new beat can be taken while an earlier total still
// waits there.
`include "assert_macros.svh"

module sliding_window_hit_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] timestamp, [31] zero fill
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [24:0] hit_total, [31:25] zero fill
);

  swhc_pkg::state_t state_r, state_nxt;

  logic [swhc_pkg::IDX_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [swhc_pkg::IDX_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [swhc_pkg::IDX_W-1:0]     rem_r, rem_nxt;
  logic [swhc_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [swhc_pkg::TS_W-1:0]      ts_r, ts_nxt;
  logic [swhc_pkg::TOTAL_W-1:0]   acc_r, acc_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [swhc_pkg::TOTAL_W-1:0]   out_total_r, out_total_nxt;

  logic                           mem_wr_en;
  logic [swhc_pkg::IDX_W-1:0]     mem_wr_addr;
  logic [swhc_pkg::ENTRY_W-1:0]   mem_wr_data;
  logic                           mem_rd_en;
  logic [swhc_pkg::IDX_W-1:0]     mem_rd_addr;
  logic [swhc_pkg::ENTRY_W-1:0]   mem_rd_data;

  logic [swhc_pkg::TS_W-1:0]      slot_time;
  logic [swhc_pkg::COUNT_W-1:0]   slot_count;
  logic [swhc_pkg::COUNT_W-1:0]   new_count;
  logic [swhc_pkg::IDX_W-1:0]     rem_calc;
  logic [swhc_pkg::DIFF_W-1:0]    diff;
  logic                           in_window;
  logic [swhc_pkg::TOTAL_W:0]     sum;
  logic [swhc_pkg::TOTAL_W-1:0]   acc_sat;
  logic                           in_beat;
  logic                           out_free;

  assign slot_time  = mem_rd_data[swhc_pkg::ENTRY_W-1:swhc_pkg::COUNT_W];
  assign slot_count = mem_rd_data[swhc_pkg::COUNT_W-1:0];

  // slot index: timestamp minus quotient times window, only the index bits matter
  assign rem_calc = ts_r[swhc_pkg::IDX_W-1:0]
                  - swhc_pkg::IDX_W'(prod_r[swhc_pkg::RECIP_SHIFT +: swhc_pkg::IDX_W]
                                     * swhc_pkg::IDX_W'(swhc_pkg::WINDOW));

  // signed age of the slot against the query time
  assign diff      = {1'b0, ts_r} - {1'b0, slot_time};
  assign in_window = $signed(diff) < $signed(swhc_pkg::DIFF_W'(swhc_pkg::WINDOW));

  assign sum     = {1'b0, acc_r} + (swhc_pkg::TOTAL_W + 1)'(slot_count);
  assign acc_sat = sum[swhc_pkg::TOTAL_W] ? swhc_pkg::TOTAL_MAX : sum[swhc_pkg::TOTAL_W-1:0];

  assign new_count = (slot_count == swhc_pkg::COUNT_MAX) ? slot_count
                                                         : slot_count + 1'b1;

  assign in_tready  = (state_r == swhc_pkg::S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - swhc_pkg::TOTAL_W){1'b0}}, out_total_r};

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    rd_addr_nxt   = rd_addr_r;
    rd_vld_nxt    = 1'b0;
    rem_nxt       = rem_r;
    prod_nxt      = prod_r;
    ts_nxt        = ts_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_total_nxt = out_total_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = clr_cnt_r;
    mem_wr_data   = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = rd_addr_r;

    unique case (state_r)
      swhc_pkg::S_CLEAR: begin
        mem_wr_en   = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == swhc_pkg::IDX_W'(swhc_pkg::WINDOW - 1)) begin
          state_nxt = swhc_pkg::S_IDLE;
        end
      end
      swhc_pkg::S_IDLE: begin
        if (in_beat) begin
          ts_nxt      = in_tdata[swhc_pkg::TS_W-1:0];
          rem_nxt     = '0;
          rd_addr_nxt = '0;
          acc_nxt     = '0;
          state_nxt   = (in_tuser == swhc_pkg::FUNC_QUERY) ? swhc_pkg::S_QRUN
                                                           : swhc_pkg::S_MOD;
        end
      end
      swhc_pkg::S_MOD: begin
        // quotient by the window sits above RECIP_SHIFT in the product
        prod_nxt  = swhc_pkg::PROD_W'(ts_r) * swhc_pkg::PROD_W'(swhc_pkg::RECIP);
        state_nxt = swhc_pkg::S_HRD;
      end
      swhc_pkg::S_HRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = rem_calc;
        rem_nxt     = rem_calc;
        state_nxt   = swhc_pkg::S_HWR;
      end
      swhc_pkg::S_HWR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = rem_r;
        if (slot_time != ts_r) begin
          mem_wr_data = {ts_r, swhc_pkg::COUNT_W'(1)};
        end else begin
          mem_wr_data = {ts_r, new_count};
        end
        state_nxt = swhc_pkg::S_IDLE;
      end
      swhc_pkg::S_QRUN: begin
        mem_rd_en   = 1'b1;
        rd_vld_nxt  = 1'b1;
        rd_addr_nxt = rd_addr_r + 1'b1;
        if (rd_vld_r && in_window) begin
          acc_nxt = acc_sat;
        end
        if (rd_addr_r == swhc_pkg::IDX_W'(swhc_pkg::WINDOW - 1)) begin
          state_nxt = swhc_pkg::S_QDRAIN;
        end
      end
      swhc_pkg::S_QDRAIN: begin
        // last slot's data arrives here
        if (in_window) begin
          acc_nxt = acc_sat;
        end
        state_nxt = swhc_pkg::S_DONE;
      end
      swhc_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = acc_r;
          state_nxt     = swhc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swhc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swhc_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      rd_addr_r   <= '0;
      rd_vld_r    <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_addr_r   <= rd_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r        <= ts_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    out_total_r <= out_total_nxt;
  end

  swhc_ram #(
    .WIDTH (swhc_pkg::ENTRY_W),
    .DEPTH (swhc_pkg::WINDOW)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  `SWHC_ASSERT(a_rem_range, rem_r < swhc_pkg::IDX_W'(swhc_pkg::WINDOW))
  `SWHC_ASSERT_NEXT(a_hit_to_mod, in_beat && (in_tuser == swhc_pkg::FUNC_HIT), state_r == swhc_pkg::S_MOD)
  `SWHC_ASSERT(a_drain_after_last, (state_r != swhc_pkg::S_QDRAIN) || ($past(rd_addr_r) == swhc_pkg::IDX_W'(swhc_pkg::WINDOW - 1)))
  `SWHC_ASSERT_NEXT(a_done_loads_out, (state_r == swhc_pkg::S_DONE) && out_free, out_valid_r && (state_r == swhc_pkg::S_IDLE))

endmodule

// ----- test/sliding_window_hit_counter_top_test.sv -----
// ----------------------------------------------------------------------------
// sliding_window_hit_counter_top_test
// Self-checking bench for the sliding window hit counter. Hit and query beats
// go in over the input stream and a scoreboard keeps its own copy of the slot
// ring to predict every window total. Directed beats cover the time extremes,
// the cleared slot at time zero, the window edge and time running backward.
// Random beats follow in phases with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sliding_window_hit_counter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASE_BEATS  = 433;
  localparam logic [swhc_pkg::TS_W-1:0] TS_TOP = {swhc_pkg::TS_W{1'b1}};

  class hit_window_scoreboard;
    logic [swhc_pkg::TS_W-1:0]    slot_time  [swhc_pkg::WINDOW];
    logic [swhc_pkg::COUNT_W-1:0] slot_count [swhc_pkg::WINDOW];
    logic [swhc_pkg::TOTAL_W-1:0] totals_due [$];
    int                           fault_count;

    function void clear_slots();
      foreach (slot_time[i]) begin
        slot_time[i]  = '0;
        slot_count[i] = '0;
      end
      totals_due.delete();
      fault_count = 0;
    endfunction

    function void note_fault(string what);
      if (fault_count < 10) begin
        $display("mismatch: %s", what);
      end
      fault_count++;
    endfunction

    // update the ring for a hit, or sum the window for a query
    function void note_beat(logic func, logic [swhc_pkg::TS_W-1:0] ts);
      int unsigned       idx;
      longint            diff;
      longint unsigned   sum;
      if (func == swhc_pkg::FUNC_HIT) begin
        idx = ts % swhc_pkg::WINDOW;
        if (slot_time[idx] != ts) begin
          slot_time[idx]  = ts;
          slot_count[idx] = 1;
        end else if (slot_count[idx] != swhc_pkg::COUNT_MAX) begin
          slot_count[idx]++;
        end
      end else begin
        sum = 0;
        for (int i = 0; i < swhc_pkg::WINDOW; i++) begin
          // slots later than the query give a negative difference and count
          diff = longint'(ts) - longint'(slot_time[i]);
          if (diff < swhc_pkg::WINDOW) begin
            sum += slot_count[i];
          end
        end
        if (sum > swhc_pkg::TOTAL_MAX) begin
          sum = swhc_pkg::TOTAL_MAX;
        end
        totals_due = {totals_due, sum[swhc_pkg::TOTAL_W-1:0]};
      end
    endfunction

    function void check_total(logic [swhc_pkg::TOTAL_W-1:0] got);
      logic [swhc_pkg::TOTAL_W-1:0] want;
      if (totals_due.size() == 0) begin
        note_fault($sformatf("hit_total %0d with no query waiting", got));
      end else begin
        want = totals_due.pop_front();
        if (got !== want) begin
          note_fault($sformatf("hit_total expected %0d actual %0d", want, got));
        end
      end
    endfunction

    function int pending();
      return totals_due.size();
    endfunction

    function void close_out();
      if (totals_due.size() != 0) begin
        note_fault($sformatf("%0d totals never arrived", totals_due.size()));
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [30:0] timestamp, [31] zero fill
  logic        in_tuser   = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [24:0] hit_total, [31:25] zero fill

  hit_window_scoreboard           sb;
  int                             send_idle_pct;
  int                             stall_pct;
  int                             cycle_count;
  logic [swhc_pkg::TS_W-1:0]      base_time;

  sliding_window_hit_counter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[sliding_window_hit_counter_top] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_total(out_tdata[swhc_pkg::TOTAL_W-1:0]);
    end
  end

  task automatic send_beat(input logic func, input logic [swhc_pkg::TS_W-1:0] ts);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 1'($urandom_range(1));
      in_tdata  <= {1'b0, swhc_pkg::TS_W'($urandom)};
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {1'b0, ts};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(func, ts);
  endtask

  // hold the sender off until every query total is back
  task automatic wait_for_totals();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_beat(swhc_pkg::FUNC_QUERY, '0);        // cleared ring sums to zero
    send_beat(swhc_pkg::FUNC_HIT,   '0);        // cleared slot already holds time zero
    send_beat(swhc_pkg::FUNC_QUERY, '0);
    send_beat(swhc_pkg::FUNC_HIT,   '0);
    // last tick inside the window, then the first tick outside
    send_beat(swhc_pkg::FUNC_QUERY, swhc_pkg::TS_W'(swhc_pkg::WINDOW - 1));
    send_beat(swhc_pkg::FUNC_QUERY, swhc_pkg::TS_W'(swhc_pkg::WINDOW));
    send_beat(swhc_pkg::FUNC_HIT,   TS_TOP);
    send_beat(swhc_pkg::FUNC_QUERY, TS_TOP);
    send_beat(swhc_pkg::FUNC_QUERY, '0);        // time going backward
    send_beat(swhc_pkg::FUNC_HIT,   swhc_pkg::TS_W'(5));
    send_beat(swhc_pkg::FUNC_HIT,   swhc_pkg::TS_W'(5));
    send_beat(swhc_pkg::FUNC_HIT,   swhc_pkg::TS_W'(5));
    // same slot, newer time
    send_beat(swhc_pkg::FUNC_HIT,   swhc_pkg::TS_W'(5 + swhc_pkg::WINDOW));
    send_beat(swhc_pkg::FUNC_QUERY, swhc_pkg::TS_W'(10));
    send_beat(swhc_pkg::FUNC_HIT,   31'h2AAA_AAAA);
    send_beat(swhc_pkg::FUNC_HIT,   31'h5555_5555);
    send_beat(swhc_pkg::FUNC_QUERY, 31'h2AAA_AAAA);
    send_beat(swhc_pkg::FUNC_QUERY, 31'h5555_5555);
    send_beat(swhc_pkg::FUNC_QUERY, TS_TOP);
  endtask

  task automatic run_random(input int beats);
    logic                      func;
    logic [swhc_pkg::TS_W-1:0] ts;
    int                        roll;
    for (int k = 0; k < beats; k++) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        func = 1'($urandom_range(1));
        ts   = swhc_pkg::TS_W'($urandom);
      end else begin
        if (roll < 12) begin
          base_time = swhc_pkg::TS_W'($urandom);
        end else if (roll < 13) begin
          base_time = TS_TOP - swhc_pkg::TS_W'($urandom_range(500));
        end else if ($urandom_range(1)) begin
          base_time = base_time + swhc_pkg::TS_W'($urandom_range(3));
        end
        ts = base_time;
        // an occasional late beat lands behind the newest slot times
        if ($urandom_range(49) == 0) begin
          ts = base_time - swhc_pkg::TS_W'($urandom_range(1, 400));
        end
        func = ($urandom_range(3) == 0) ? swhc_pkg::FUNC_QUERY : swhc_pkg::FUNC_HIT;
      end
      send_beat(func, ts);
    end
  endtask

  initial begin
    sb = new;
    sb.clear_slots();
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    base_time     = swhc_pkg::TS_W'($urandom);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      run_random(PHASE_BEATS / 2);
      if (p == 2) begin
        wait_for_totals();
      end
      run_random(PHASE_BEATS - PHASE_BEATS / 2);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.fault_count == 0) begin
      $display("[sliding_window_hit_counter_top] OK");
    end else begin
      $display("[sliding_window_hit_counter_top] ERROR");
    end
    $finish;
  end

endmodule
